/* hw/rtl/smeu_pkg.sv */
// Shared types, opcodes, status codes and default sizes of the stack machine execute unit.
package smeu_pkg;

    localparam int VALUE_DEPTH_DEF = 1024;
    localparam int CALL_DEPTH_DEF  = 256;
    localparam int HEAP_WORDS_DEF  = 1024;
    localparam int PC_BITS_DEF     = 16;

    localparam int DEPTH_W = 11;
    localparam int RPC_W   = 16;

    localparam logic [4:0] OP_PUSH     = 5'd0;
    localparam logic [4:0] OP_DUP      = 5'd1;
    localparam logic [4:0] OP_REF      = 5'd2;
    localparam logic [4:0] OP_SWAP     = 5'd3;
    localparam logic [4:0] OP_DISCARD  = 5'd4;
    localparam logic [4:0] OP_SLIDE    = 5'd5;
    localparam logic [4:0] OP_ADD      = 5'd6;
    localparam logic [4:0] OP_SUB      = 5'd7;
    localparam logic [4:0] OP_MUL      = 5'd8;
    localparam logic [4:0] OP_DIV      = 5'd9;
    localparam logic [4:0] OP_MOD      = 5'd10;
    localparam logic [4:0] OP_STORE    = 5'd11;
    localparam logic [4:0] OP_RETRIEVE = 5'd12;
    localparam logic [4:0] OP_CALL     = 5'd13;
    localparam logic [4:0] OP_BZ       = 5'd14;
    localparam logic [4:0] OP_BN       = 5'd15;
    localparam logic [4:0] OP_RET      = 5'd16;
    localparam logic [4:0] OP_OUTCHAR  = 5'd17;
    localparam logic [4:0] OP_OUTNUM   = 5'd18;
    localparam logic [4:0] OP_RDCHAR   = 5'd19;
    localparam logic [4:0] OP_RDNUM    = 5'd20;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_OVERFLOW   = 3'd1;
    localparam logic [2:0] ST_UNDERFLOW  = 3'd2;
    localparam logic [2:0] ST_RANGE      = 3'd3;
    localparam logic [2:0] ST_DIV_ZERO   = 3'd4;
    localparam logic [2:0] ST_HEAP_ADDR  = 3'd5;
    localparam logic [2:0] ST_CALL_OVER  = 3'd6;
    localparam logic [2:0] ST_CALL_UNDER = 3'd7;

    typedef struct packed {
        logic [4:0]         req_type;
        logic signed [31:0] immediate;
        logic [15:0]        pc_value;
        logic signed [31:0] read_value;
    } smeu_req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic               branch_taken;
        logic [15:0]        return_pc;
        logic               emit_valid;
        logic               emit_char;
        logic signed [31:0] emit_value;
        logic [10:0]        depth;
    } smeu_rsp_t;

    typedef struct packed {
        logic        start;
        logic        want_rem;
        logic [31:0] dividend;
        logic [31:0] divisor;
    } smeu_div_cmd_t;

endpackage

/* hw/rtl/stack_machine_execute_unit.sv */
// Top level of the stack machine execute unit: sequencer, stack and heap memories.
// Executes one stack-machine instruction per request beat and returns one response
// beat for it. The value stack, call stack and heap are synchronous memories with
// registered read data, so an instruction walks read, read, execute, write back and
// respond (S_RD1, S_RD2, S_EXEC, S_WB, S_DONE) before the next accept; swap adds
// S_SWAP2, retrieve adds S_HEAP, and divide and modulo wait in S_DIV for the 32-step
// divider. A faulting instruction changes no state; a fault seen at accept goes
// straight to S_DONE, and a divide by zero or a bad heap address, seen after the
// stack reads, goes to S_DONE from S_EXEC. After reset the heap is swept to zero,
// one word per cycle over all HEAP_WORDS words, while requests are stalled.
module stack_machine_execute_unit
    import smeu_pkg::*;
#(
    parameter int VALUE_DEPTH = VALUE_DEPTH_DEF,
    parameter int CALL_DEPTH  = CALL_DEPTH_DEF,
    parameter int HEAP_WORDS  = HEAP_WORDS_DEF,
    parameter int PC_BITS     = PC_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  smeu_req_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output smeu_rsp_t rsp
);

    localparam int VA = $clog2(VALUE_DEPTH);
    localparam int VT = $clog2(VALUE_DEPTH + 1);
    localparam int CA = $clog2(CALL_DEPTH);
    localparam int CT = $clog2(CALL_DEPTH + 1);
    localparam int HA = $clog2(HEAP_WORDS);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD1   = 4'd2;
    localparam logic [3:0] S_RD2   = 4'd3;
    localparam logic [3:0] S_EXEC  = 4'd4;
    localparam logic [3:0] S_DIV   = 4'd5;
    localparam logic [3:0] S_HEAP  = 4'd6;
    localparam logic [3:0] S_WB    = 4'd7;
    localparam logic [3:0] S_SWAP2 = 4'd8;
    localparam logic [3:0] S_DONE  = 4'd9;

    logic [3:0]         state_reg, state_next;
    logic [VT-1:0]      top_reg, top_next;
    logic [CT-1:0]      ctop_reg, ctop_next;
    logic [HA-1:0]      clr_reg;
    logic [4:0]         op_reg;
    logic [31:0]        imm_reg;
    logic [PC_BITS-1:0] pc_reg;
    logic [31:0]        rdv_reg;
    logic [2:0]         st_reg;
    logic [31:0]        a_reg;
    logic [31:0]        b_reg;
    logic [31:0]        res_reg;
    logic               rsp_valid_reg;
    smeu_rsp_t          rsp_reg, rsp_next;

    logic [31:0]        vs_mem [VALUE_DEPTH];
    logic               vs_we, vs_re;
    logic [VA-1:0]      vs_waddr, vs_raddr;
    logic [31:0]        vs_wdata, vs_rdata;

    logic [PC_BITS-1:0] cs_mem [CALL_DEPTH];
    logic               cs_we, cs_re;
    logic [CA-1:0]      cs_waddr, cs_raddr;
    logic [PC_BITS-1:0] cs_wdata, cs_rdata;

    logic [31:0]        hp_mem [HEAP_WORDS];
    logic               hp_we, hp_re;
    logic [HA-1:0]      hp_waddr, hp_raddr;
    logic [31:0]        hp_wdata, hp_rdata;

    logic               acc;
    logic               rsp_load;
    logic [31:0]        immu;
    logic [31:0]        t32;
    logic [VT-1:0]      t_m1, t_m2;
    logic [31:0]        ref_idx;
    logic [VT-1:0]      slide_top;
    logic [VT-1:0]      slide_dst;
    logic               t_zero, t_lt2, t_full, c_full, c_zero, imm_lt_t;
    logic [2:0]         early_st;
    logic [2:0]         late_st;
    logic               is_divop;
    logic [PC_BITS-1:0] rpc_w;

    smeu_div_cmd_t      div_cmd;
    logic               div_done;
    logic [31:0]        div_result;

    smeu_div u_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (div_cmd),
        .done   (div_done),
        .result (div_result)
    );

    always_ff @(posedge clk)
    begin
        if (vs_we)
            vs_mem[vs_waddr] <= vs_wdata;
        if (vs_re)
            vs_rdata <= vs_mem[vs_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cs_we)
            cs_mem[cs_waddr] <= cs_wdata;
        if (cs_re)
            cs_rdata <= cs_mem[cs_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (hp_we)
            hp_mem[hp_waddr] <= hp_wdata;
        if (hp_re)
            hp_rdata <= hp_mem[hp_raddr];
    end

    assign req_stall = (state_reg != S_IDLE);
    assign acc       = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_load  = (state_reg == S_DONE) && (!rsp_valid_reg || !rsp_stall);

    always_comb
    begin
        immu      = req.immediate;
        t32       = 32'(top_reg);
        t_m1      = top_reg - VT'(1);
        t_m2      = top_reg - VT'(2);
        ref_idx   = t32 - 32'd1 - immu;
        slide_top = top_reg - imm_reg[VT-1:0];
        slide_dst = slide_top - VT'(1);
        t_zero    = (top_reg == '0);
        t_lt2     = (top_reg < VT'(2));
        t_full    = (top_reg == VT'(VALUE_DEPTH));
        c_full    = (ctop_reg == CT'(CALL_DEPTH));
        c_zero    = (ctop_reg == '0);
        imm_lt_t  = !immu[31] && (immu < t32);
        is_divop  = (op_reg == OP_DIV) || (op_reg == OP_MOD);
        rpc_w     = cs_rdata + PC_BITS'(1);
    end

    always_comb
    begin
        case (req.req_type)
            OP_PUSH:     early_st = t_full ? ST_OVERFLOW : ST_OK;
            OP_DUP:      early_st = t_zero ? ST_UNDERFLOW : (t_full ? ST_OVERFLOW : ST_OK);
            OP_REF:      early_st = !imm_lt_t ? ST_RANGE : (t_full ? ST_OVERFLOW : ST_OK);
            OP_SWAP,
            OP_ADD,
            OP_SUB,
            OP_MUL,
            OP_DIV,
            OP_MOD,
            OP_STORE:    early_st = t_lt2 ? ST_UNDERFLOW : ST_OK;
            OP_SLIDE:
            begin
                if (t_zero)
                    early_st = ST_UNDERFLOW;
                else if (immu[31])
                    early_st = ST_RANGE;
                else if (!imm_lt_t)
                    early_st = ST_UNDERFLOW;
                else
                    early_st = ST_OK;
            end
            OP_DISCARD,
            OP_RETRIEVE,
            OP_BZ,
            OP_BN,
            OP_OUTCHAR,
            OP_OUTNUM,
            OP_RDCHAR,
            OP_RDNUM:    early_st = t_zero ? ST_UNDERFLOW : ST_OK;
            OP_CALL:     early_st = c_full ? ST_CALL_OVER : ST_OK;
            OP_RET:      early_st = c_zero ? ST_CALL_UNDER : ST_OK;
            default:     early_st = ST_OK;
        endcase
    end

    always_comb
    begin
        late_st = ST_OK;
        if (is_divop && (a_reg == 32'd0))
            late_st = ST_DIV_ZERO;
        else if ((op_reg == OP_STORE) && (b_reg >= 32'(HEAP_WORDS)))
            late_st = ST_HEAP_ADDR;
        else if (((op_reg == OP_RETRIEVE) || (op_reg == OP_RDCHAR) || (op_reg == OP_RDNUM))
                 && (a_reg >= 32'(HEAP_WORDS)))
            late_st = ST_HEAP_ADDR;
    end

    always_comb
    begin
        div_cmd.start    = (state_reg == S_EXEC) && is_divop && (late_st == ST_OK);
        div_cmd.want_rem = (op_reg == OP_MOD);
        div_cmd.dividend = b_reg;
        div_cmd.divisor  = a_reg;
    end

    // memory ports and stack pointers
    always_comb
    begin
        vs_we     = 1'b0;
        vs_waddr  = t_m1[VA-1:0];
        vs_wdata  = res_reg;
        vs_re     = 1'b0;
        vs_raddr  = t_m1[VA-1:0];
        cs_we     = 1'b0;
        cs_waddr  = ctop_reg[CA-1:0];
        cs_wdata  = pc_reg;
        cs_re     = acc;
        cs_raddr  = ctop_reg[CA-1:0] - CA'(1);
        hp_we     = 1'b0;
        hp_waddr  = clr_reg;
        hp_wdata  = '0;
        hp_re     = 1'b0;
        hp_raddr  = a_reg[HA-1:0];
        top_next  = top_reg;
        ctop_next = ctop_reg;

        case (state_reg)
            S_CLEAR:
                hp_we = 1'b1;
            S_IDLE:
            begin
                vs_re = acc;
                if (req.req_type == OP_REF)
                    vs_raddr = ref_idx[VA-1:0];
            end
            S_RD1:
            begin
                vs_re    = 1'b1;
                vs_raddr = t_m2[VA-1:0];
            end
            S_EXEC:
                hp_re = (op_reg == OP_RETRIEVE);
            S_WB:
            begin
                case (op_reg)
                    OP_PUSH, OP_DUP, OP_REF:
                    begin
                        vs_we    = 1'b1;
                        vs_waddr = top_reg[VA-1:0];
                        top_next = top_reg + VT'(1);
                    end
                    OP_SWAP:
                    begin
                        vs_we    = 1'b1;
                        vs_wdata = b_reg;
                    end
                    OP_SLIDE:
                    begin
                        vs_we    = 1'b1;
                        vs_waddr = slide_dst[VA-1:0];
                        vs_wdata = a_reg;
                        top_next = slide_top;
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD:
                    begin
                        vs_we    = 1'b1;
                        vs_waddr = t_m2[VA-1:0];
                        top_next = t_m1;
                    end
                    OP_STORE:
                    begin
                        hp_we    = 1'b1;
                        hp_waddr = b_reg[HA-1:0];
                        hp_wdata = a_reg;
                        top_next = t_m2;
                    end
                    OP_RETRIEVE:
                        vs_we = 1'b1;
                    OP_CALL:
                    begin
                        cs_we     = 1'b1;
                        ctop_next = ctop_reg + CT'(1);
                    end
                    OP_RET:
                        ctop_next = ctop_reg - CT'(1);
                    OP_RDCHAR, OP_RDNUM:
                    begin
                        hp_we    = 1'b1;
                        hp_waddr = a_reg[HA-1:0];
                        hp_wdata = rdv_reg;
                        top_next = t_m1;
                    end
                    OP_DISCARD, OP_BZ, OP_BN, OP_OUTCHAR, OP_OUTNUM:
                        top_next = t_m1;
                    default:
                    begin
                    end
                endcase
            end
            S_SWAP2:
            begin
                vs_we    = 1'b1;
                vs_waddr = t_m2[VA-1:0];
                vs_wdata = a_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
                if (clr_reg == HA'(HEAP_WORDS - 1))
                    state_next = S_IDLE;
            S_IDLE:
                if (acc)
                    state_next = (early_st == ST_OK) ? S_RD1 : S_DONE;
            S_RD1:
                state_next = S_RD2;
            S_RD2:
                state_next = S_EXEC;
            S_EXEC:
            begin
                if (late_st != ST_OK)
                    state_next = S_DONE;
                else if (is_divop)
                    state_next = S_DIV;
                else if (op_reg == OP_RETRIEVE)
                    state_next = S_HEAP;
                else
                    state_next = S_WB;
            end
            S_DIV:
                if (div_done)
                    state_next = S_WB;
            S_HEAP:
                state_next = S_WB;
            S_WB:
                state_next = (op_reg == OP_SWAP) ? S_SWAP2 : S_DONE;
            S_SWAP2:
                state_next = S_DONE;
            S_DONE:
                if (rsp_load)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        rsp_next              = '0;
        rsp_next.status       = st_reg;
        rsp_next.depth        = DEPTH_W'(top_reg);
        if (st_reg == ST_OK)
        begin
            if (op_reg == OP_BZ)
                rsp_next.branch_taken = (a_reg == 32'd0);
            else if (op_reg == OP_BN)
                rsp_next.branch_taken = a_reg[31];
            if (op_reg == OP_RET)
                rsp_next.return_pc = RPC_W'(rpc_w);
            if ((op_reg == OP_OUTCHAR) || (op_reg == OP_OUTNUM))
            begin
                rsp_next.emit_valid = 1'b1;
                rsp_next.emit_char  = (op_reg == OP_OUTCHAR);
                rsp_next.emit_value = a_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            top_reg       <= '0;
            ctop_reg      <= '0;
            clr_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            top_reg   <= top_next;
            ctop_reg  <= ctop_next;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + HA'(1);
            if (rsp_load)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            op_reg  <= req.req_type;
            imm_reg <= req.immediate;
            pc_reg  <= PC_BITS'(req.pc_value);
            rdv_reg <= req.read_value;
            st_reg  <= early_st;
        end
        if (state_reg == S_RD1)
            a_reg <= vs_rdata;
        if (state_reg == S_RD2)
            b_reg <= vs_rdata;
        if (state_reg == S_EXEC)
        begin
            st_reg <= late_st;
            case (op_reg)
                OP_PUSH: res_reg <= imm_reg;
                OP_ADD:  res_reg <= b_reg + a_reg;
                OP_SUB:  res_reg <= b_reg - a_reg;
                OP_MUL:  res_reg <= 32'(b_reg * a_reg);
                default: res_reg <= a_reg;
            endcase
        end
        if ((state_reg == S_DIV) && div_done)
            res_reg <= div_result;
        if (state_reg == S_HEAP)
            res_reg <= hp_rdata;
        if (rsp_load)
            rsp_reg <= rsp_next;
    end

    a_top_bound: assert property (@(posedge clk) disable iff (!rst_n)
        top_reg <= VT'(VALUE_DEPTH))
        else $error("value stack pointer past its depth");

    a_ctop_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctop_reg <= CT'(CALL_DEPTH))
        else $error("call stack pointer past its depth");

    a_fault_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != ST_OK)
        |-> !rsp.emit_valid && !rsp.branch_taken && (rsp.return_pc == '0))
        else $error("faulting beat carries a result");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> (state_reg != S_IDLE))
        else $error("sequencer idle after accepting a beat");

    a_fault_keeps_top: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) && acc && (early_st != ST_OK) |=> $stable(top_reg))
        else $error("faulting instruction moved the stack pointer");

endmodule

/* hw/rtl/smeu_div.sv */
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
module smeu_div
    import smeu_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  smeu_div_cmd_t cmd,
    output logic          done,
    output logic [31:0]   result
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dsr_reg;
    logic        neg_q_reg;
    logic        neg_r_reg;
    logic        want_rem_reg;
    logic [31:0] result_reg;

    logic [32:0] rem_sh;
    logic [32:0] diff;
    logic        ge;
    logic [31:0] rem_new;
    logic [31:0] quo_new;
    logic [31:0] mag_a;
    logic [31:0] mag_b;

    always_comb
    begin
        rem_sh  = {rem_reg, quo_reg[31]};
        diff    = rem_sh - {1'b0, dsr_reg};
        ge      = !diff[32];
        rem_new = ge ? diff[31:0] : rem_sh[31:0];
        quo_new = {quo_reg[30:0], ge};
        mag_a   = cmd.dividend[31] ? (32'd0 - cmd.dividend) : cmd.dividend;
        mag_b   = cmd.divisor[31] ? (32'd0 - cmd.divisor) : cmd.divisor;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cmd.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start && !busy_reg)
        begin
            rem_reg      <= '0;
            quo_reg      <= mag_a;
            dsr_reg      <= mag_b;
            neg_q_reg    <= cmd.dividend[31] ^ cmd.divisor[31];
            neg_r_reg    <= cmd.dividend[31];
            want_rem_reg <= cmd.want_rem;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_new;
            quo_reg <= quo_new;
            if (cnt_reg == 5'd31)
            begin
                if (want_rem_reg)
                    result_reg <= neg_r_reg ? (32'd0 - rem_new) : rem_new;
                else
                    result_reg <= neg_q_reg ? (32'd0 - quo_new) : quo_new;
            end
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* tb/smeu_checker.sv */
// Checker for the stack machine execute unit: predicts each response beat and compares it.
`timescale 1ns / 100ps
module smeu_checker
    import smeu_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    input  logic      req_stall,
    input  smeu_req_t req,
    input  logic      rsp_valid,
    input  logic      rsp_stall,
    input  smeu_rsp_t rsp,
    output int        fail_count,
    output int        pending,
    output int        rsp_seen
);

    logic [31:0] vstack [VALUE_DEPTH_DEF];
    logic [15:0] cstack [CALL_DEPTH_DEF];
    logic [31:0] heap   [HEAP_WORDS_DEF];
    int          vtop;
    int          ctop;
    smeu_rsp_t   expected_q [$];

    function automatic logic [31:0] sdivide(logic [31:0] a, logic [31:0] b, bit want_rem);
        logic [31:0] ma;
        logic [31:0] mb;
        logic [31:0] q;
        logic [31:0] r;
        ma = a[31] ? -a : a;
        mb = b[31] ? -b : b;
        q = ma / mb;
        r = ma % mb;
        if (want_rem)
            return a[31] ? -r : r;
        return (a[31] != b[31]) ? -q : q;
    endfunction

    function automatic smeu_rsp_t execute(smeu_req_t r);
        smeu_rsp_t   o;
        logic [31:0] x;
        logic [31:0] y;
        longint      idx;
        int          t;
        o = '0;
        t = vtop;
        case (r.req_type)
            OP_PUSH:
                if (t >= VALUE_DEPTH_DEF) o.status = ST_OVERFLOW;
                else begin vstack[t] = r.immediate; vtop = t + 1; end
            OP_DUP:
                if (t == 0) o.status = ST_UNDERFLOW;
                else if (t >= VALUE_DEPTH_DEF) o.status = ST_OVERFLOW;
                else begin vstack[t] = vstack[t-1]; vtop = t + 1; end
            OP_REF:
            begin
                idx = longint'(t) - longint'(r.immediate) - 1;
                if (idx < 0 || idx >= t) o.status = ST_RANGE;
                else if (t >= VALUE_DEPTH_DEF) o.status = ST_OVERFLOW;
                else begin vstack[t] = vstack[idx]; vtop = t + 1; end
            end
            OP_SWAP:
                if (t < 2) o.status = ST_UNDERFLOW;
                else
                begin
                    x = vstack[t-1];
                    vstack[t-1] = vstack[t-2];
                    vstack[t-2] = x;
                end
            OP_DISCARD:
                if (t == 0) o.status = ST_UNDERFLOW;
                else vtop = t - 1;
            OP_SLIDE:
                if (t == 0) o.status = ST_UNDERFLOW;
                else if (r.immediate < 0) o.status = ST_RANGE;
                else if (r.immediate > t - 1) o.status = ST_UNDERFLOW;
                else
                begin
                    x = vstack[t-1];
                    vtop = t - r.immediate;
                    vstack[vtop-1] = x;
                end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD:
                if (t < 2) o.status = ST_UNDERFLOW;
                else
                begin
                    y = vstack[t-1];
                    x = vstack[t-2];
                    if ((r.req_type == OP_DIV || r.req_type == OP_MOD) && y == 0)
                        o.status = ST_DIV_ZERO;
                    else
                    begin
                        case (r.req_type)
                            OP_ADD:  x = x + y;
                            OP_SUB:  x = x - y;
                            OP_MUL:  x = x * y;
                            default: x = sdivide(x, y, r.req_type == OP_MOD);
                        endcase
                        vstack[t-2] = x;
                        vtop = t - 1;
                    end
                end
            OP_STORE:
                if (t < 2) o.status = ST_UNDERFLOW;
                else if (vstack[t-2] >= HEAP_WORDS_DEF) o.status = ST_HEAP_ADDR;
                else begin heap[vstack[t-2]] = vstack[t-1]; vtop = t - 2; end
            OP_RETRIEVE:
                if (t == 0) o.status = ST_UNDERFLOW;
                else if (vstack[t-1] >= HEAP_WORDS_DEF) o.status = ST_HEAP_ADDR;
                else vstack[t-1] = heap[vstack[t-1]];
            OP_CALL:
                if (ctop >= CALL_DEPTH_DEF) o.status = ST_CALL_OVER;
                else begin cstack[ctop] = r.pc_value; ctop++; end
            OP_BZ, OP_BN:
                if (t == 0) o.status = ST_UNDERFLOW;
                else
                begin
                    x = vstack[t-1];
                    o.branch_taken = (r.req_type == OP_BZ) ? (x == 0) : x[31];
                    vtop = t - 1;
                end
            OP_RET:
                if (ctop == 0) o.status = ST_CALL_UNDER;
                else begin ctop--; o.return_pc = cstack[ctop] + 16'd1; end
            OP_OUTCHAR, OP_OUTNUM:
                if (t == 0) o.status = ST_UNDERFLOW;
                else
                begin
                    o.emit_valid = 1'b1;
                    o.emit_char = (r.req_type == OP_OUTCHAR);
                    o.emit_value = vstack[t-1];
                    vtop = t - 1;
                end
            OP_RDCHAR, OP_RDNUM:
                if (t == 0) o.status = ST_UNDERFLOW;
                else if (vstack[t-1] >= HEAP_WORDS_DEF) o.status = ST_HEAP_ADDR;
                else begin heap[vstack[t-1]] = r.read_value; vtop = t - 1; end
            default: ;
        endcase
        o.depth = vtop[10:0];
        return o;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vtop = 0;
            ctop = 0;
            fail_count <= 0;
            rsp_seen <= 0;
            expected_q.delete();
            for (int i = 0; i < HEAP_WORDS_DEF; i++)
                heap[i] = '0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                rsp_seen <= rsp_seen + 1;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual %p", $time, rsp);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    if (expected_q[0] !== rsp)
                    begin
                        $display("%0t: mismatch, expected %p, actual %p", $time,
                                 expected_q[0], rsp);
                        fail_count <= fail_count + 1;
                    end
                    void'(expected_q.pop_front());
                end
            end
            if (req_valid && !req_stall)
                expected_q.push_back(execute(req));
        end
    end

endmodule

/* tb/tb_stack_machine_execute_unit.sv */
// Testbench top for the stack machine execute unit: stimulus, idling and verdict.
`timescale 1ns / 100ps
module tb_stack_machine_execute_unit;
    import smeu_pkg::*;

    localparam logic [4:0] OP_UNUSED = 5'd31;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      req_valid = 1'b0;
    logic      req_stall;
    smeu_req_t req = '0;
    logic      rsp_valid;
    logic      rsp_stall = 1'b0;
    smeu_rsp_t rsp;
    int        fail_count;
    int        pending;
    int        rsp_seen;
    bit        quiet_phase = 1'b0;
    int        model_depth = 0;
    int        sent = 0;

    always #2 clk = ~clk;

    stack_machine_execute_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    smeu_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending),
        .rsp_seen   (rsp_seen)
    );

    always @(posedge clk)
    begin
        if (quiet_phase || $urandom_range(0, 9) > 2)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= 1'b1;
    end

    task automatic send_beat(logic [4:0] op, logic [31:0] imm, logic [15:0] pcv,
                             logic [31:0] rdv);
        smeu_req_t r;
        r.req_type = op;
        r.immediate = imm;
        r.pc_value = pcv;
        r.read_value = rdv;
        if (!quiet_phase && $urandom_range(0, 4) == 0)
        begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        req_valid <= 1'b1;
        req <= r;
        @(posedge clk);
        while (req_stall) @(posedge clk);
        sent++;
    endtask

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return $urandom_range(0, 3);
            4: return $urandom_range(0, HEAP_WORDS_DEF + 8);
            default: return $urandom;
        endcase
    endfunction

    task automatic random_beat();
        logic [4:0]  op;
        logic [31:0] imm;
        int          d;
        d = model_depth;
        if (d < 4 || (d < 40 && $urandom_range(0, 2) == 0))
            op = OP_PUSH;
        else
            op = 5'($urandom_range(0, 31));
        if (d > 1000 && op inside {OP_PUSH, OP_DUP, OP_REF})
            op = OP_DISCARD;
        case (op)
            OP_REF:   imm = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, d);
            OP_SLIDE: imm = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 3);
            default:  imm = rand_word();
        endcase
        send_beat(op, imm, 16'($urandom), $urandom);
        // track depth loosely, then take the checker's depth, to keep the stack busy but bounded
        case (op)
            OP_PUSH, OP_DUP, OP_REF: model_depth = d + 1;
            OP_CALL, OP_RET, OP_SWAP, OP_RETRIEVE: ;
            OP_STORE: if (d >= 2) model_depth = d - 2;
            OP_SLIDE: ;
            default: if (op <= OP_RDNUM && d > 0) model_depth = d - 1;
        endcase
        model_depth = u_checker.vtop;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_beat(OP_DISCARD, 0, 0, 0);
        send_beat(OP_RET, 0, 0, 0);
        send_beat(OP_SLIDE, 0, 0, 0);
        send_beat(OP_PUSH, 32'h8000_0000, 0, 0);
        send_beat(OP_PUSH, 32'hffff_ffff, 0, 0);
        send_beat(OP_DIV, 0, 0, 0);
        send_beat(OP_PUSH, 32'h7fff_ffff, 0, 0);
        send_beat(OP_PUSH, 0, 0, 0);
        send_beat(OP_MOD, 0, 0, 0);
        send_beat(OP_REF, 32'hffff_ffff, 0, 0);
        send_beat(OP_REF, 1, 0, 0);
        send_beat(OP_SLIDE, 32'h8000_0000, 0, 0);
        send_beat(OP_SLIDE, 5, 0, 0);
        send_beat(OP_PUSH, HEAP_WORDS_DEF - 1, 0, 0);
        send_beat(OP_RETRIEVE, 0, 0, 0);
        send_beat(OP_STORE, 0, 0, 0);
        send_beat(OP_PUSH, HEAP_WORDS_DEF, 0, 0);
        send_beat(OP_RDNUM, 0, 0, 32'h8000_0000);
        send_beat(OP_CALL, 0, 16'hffff, 0);
        send_beat(OP_RET, 0, 0, 0);
        send_beat(OP_OUTCHAR, 0, 0, 0);
        send_beat(OP_BN, 0, 0, 0);
        send_beat(OP_UNUSED, 32'hffff_ffff, 16'hffff, 32'hffff_ffff);
        repeat (1026) send_beat(OP_PUSH, $urandom, 0, 0);
        repeat (258) send_beat(OP_CALL, 0, 16'($urandom), 0);
        repeat (259) send_beat(OP_RET, 0, 0, 0);
        send_beat(OP_SLIDE, VALUE_DEPTH_DEF - 1, 0, 0);
        send_beat(OP_DISCARD, 0, 0, 0);
        model_depth = 0;
        for (int i = 0; i < 450; i++)
        begin
            if (i == 380)
                quiet_phase = 1'b1;
            random_beat();
        end
        req_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        $display("Covered %0d request beats and %0d response beats: all opcodes,", sent,
                 rsp_seen);
        $display("stack and call limits, heap range, divide edge cases and random programs.");
        if (fail_count == 0)
            $display("tb_stack_machine_execute_unit: clean");
        else
            $display("tb_stack_machine_execute_unit: errors");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb_stack_machine_execute_unit: errors");
        $finish;
    end

endmodule
